FILE: rtl/epq_pkg.sv
// Shared types, constants and codes for the endpoint probability qualifier.
package epq_pkg;

  localparam int          WINDOW_DEFAULT  = 5;
  localparam logic [15:0] PROB_ONE        = 16'd32768;
  localparam logic [15:0] CONF_HALF       = 16'd16384;
  localparam logic [7:0]  RUN_MAX         = 8'd255;
  localparam logic [15:0] THRESHOLD_RESET = 16'd27853;
  localparam logic [7:0]  PERSIST_RESET   = 8'd3;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_THRESHOLD   = 1'b0,
    CFG_PERSISTENCE = 1'b1
  } cfg_idx_t;

  typedef enum logic {
    KIND_SAMPLE  = 1'b0,
    KIND_RESTART = 1'b1
  } kind_t;

  typedef struct packed {
    logic        kind;
    logic [15:0] raw_probability;
    logic [15:0] confidence;
  } in_item_t;

  typedef struct packed {
    logic [15:0] smoothed_probability;
    logic        frame_passes;
    logic [7:0]  run_length;
    logic        endpoint_flag;
  } out_item_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clear;
  } win_cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_START,
    ST_DIV,
    ST_DONE
  } state_t;

endpackage

FILE: rtl/epq_window.sv
// Sample window: one-port memory with running sum, fill count and write slot.
module epq_window import epq_pkg::*; #(
  parameter int WINDOW = WINDOW_DEFAULT,
  localparam int SUM_W  = $clog2(WINDOW * int'(PROB_ONE) + 1),
  localparam int FILL_W = $clog2(WINDOW + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  win_cmd_t          cmd,
  input  logic [15:0]       wr_data,
  output logic [SUM_W-1:0]  sum,
  output logic [FILL_W-1:0] fill
);

  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  logic [15:0]       mem [WINDOW];
  logic [15:0]       rd_data_r;
  logic [SUM_W-1:0]  sum_r, sum_nxt;
  logic [FILL_W-1:0] fill_r;
  logic [SLOT_W-1:0] slot_r, slot_nxt;
  logic              full;

  assign full = (fill_r == FILL_W'(WINDOW));

  always_comb begin
    sum_nxt = sum_r + SUM_W'(wr_data);
    if (full) begin
      sum_nxt = sum_nxt - SUM_W'(rd_data_r);
    end
    slot_nxt = (slot_r == SLOT_W'(WINDOW - 1)) ? '0 : slot_r + 1'b1;
  end

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_data_r <= mem[slot_r];
    end
    if (cmd.wr_en) begin
      mem[slot_r] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || cmd.clear) begin
      sum_r  <= '0;
      fill_r <= '0;
      slot_r <= '0;
    end else if (cmd.wr_en) begin
      sum_r  <= sum_nxt;
      slot_r <= slot_nxt;
      if (!full) begin
        fill_r <= fill_r + 1'b1;
      end
    end
  end

  assign sum  = sum_r;
  assign fill = fill_r;

endmodule

FILE: rtl/epq_div.sv
// Restoring divider, one quotient bit per cycle.
module epq_div import epq_pkg::*; #(
  parameter int DIVIDEND_W = 18,
  parameter int DIVISOR_W  = 3
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [DIVIDEND_W-1:0] dividend,
  input  logic [DIVISOR_W-1:0]  divisor,
  output logic                  done,
  output logic [DIVIDEND_W-1:0] quotient
);

  localparam int CNT_W = $clog2(DIVIDEND_W + 1);

  logic [DIVIDEND_W-1:0] quo_r;
  logic [DIVISOR_W-1:0]  rem_r, rem_nxt;
  logic [DIVISOR_W-1:0]  divisor_r;
  logic [CNT_W-1:0]      cnt_r;
  logic                  busy_r;
  logic                  done_r;
  logic [DIVISOR_W:0]    trial;
  logic                  qbit;

  always_comb begin
    trial = {rem_r, quo_r[DIVIDEND_W-1]};
    qbit  = (trial >= {1'b0, divisor_r});
    if (qbit) begin
      rem_nxt = DIVISOR_W'(trial - {1'b0, divisor_r});
    end else begin
      rem_nxt = trial[DIVISOR_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quo_r     <= dividend;
      rem_r     <= '0;
      divisor_r <= divisor;
    end else if (busy_r) begin
      quo_r <= {quo_r[DIVIDEND_W-2:0], qbit};
      rem_r <= rem_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(DIVIDEND_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = quo_r;

endmodule

FILE: rtl/endpoint_probability_qualifier_top.sv
// Top level: sequencer, run counter, registers and output stage.
//
//   port group | direction | handshake           | payload
//   in_        | input     | in_valid / in_stall   | in_item_t
//   out_       | output    | out_valid / out_stall | out_item_t
//   cfg_       | input     | cfg_wr_en             | cfg_index, cfg_wdata
//
// A sample's result is valid after it is accepted and has passed through
// window read, update, divide start, the bit-serial divide of the window sum
// by the fill count, then the output load. The next transaction is taken only
// once the block is idle again after that load.
// A restart clears the window and run length and gives no transaction.
// Reset is synchronous; the window memory itself is not cleared.
// The output register holds a result under out_stall while the next sample
// is worked on; that sample waits at the end until the register is free.
module endpoint_probability_qualifier_top import epq_pkg::*; #(
  parameter int WINDOW = WINDOW_DEFAULT
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_wr_en,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int SUM_W  = $clog2(WINDOW * int'(PROB_ONE) + 1);
  localparam int FILL_W = $clog2(WINDOW + 1);

  state_t            state_r, state_nxt;
  win_cmd_t          cmd;
  logic              in_accept;
  logic              out_free;
  logic [15:0]       prob_r;
  logic [15:0]       conf_r;
  logic [15:0]       thr_r;
  logic [7:0]        persist_r;
  logic [7:0]        run_r, run_nxt;
  logic              out_valid_r;
  out_item_t         out_data_r, out_data_nxt;
  logic              out_load;
  logic              div_start;
  logic              div_done;
  logic [SUM_W-1:0]  win_sum;
  logic [FILL_W-1:0] win_fill;
  logic [SUM_W-1:0]  quotient;
  logic [15:0]       mean;
  logic              passes;

  assign in_stall  = (state_r != ST_IDLE);
  assign in_accept = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  epq_window #(.WINDOW(WINDOW)) u_window (
    .clk     (clk),
    .rst_n   (rst_n),
    .cmd     (cmd),
    .wr_data (prob_r),
    .sum     (win_sum),
    .fill    (win_fill)
  );

  epq_div #(.DIVIDEND_W(SUM_W), .DIVISOR_W(FILL_W)) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (win_sum),
    .divisor  (win_fill),
    .done     (div_done),
    .quotient (quotient)
  );

  assign mean   = quotient[15:0];
  assign passes = (mean >= thr_r) && (conf_r > CONF_HALF);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    div_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          if (in_data.kind == KIND_RESTART) begin
            cmd.clear = 1'b1;
          end else begin
            state_nxt = ST_READ;
          end
        end
      end
      ST_READ: begin
        cmd.rd_en = 1'b1;
        state_nxt = ST_UPDATE;
      end
      ST_UPDATE: begin
        cmd.wr_en = 1'b1;
        state_nxt = ST_START;
      end
      ST_START: begin
        div_start = 1'b1;
        state_nxt = ST_DIV;
      end
      ST_DIV: begin
        if (div_done) begin
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    if (!passes) begin
      run_nxt = '0;
    end else if (run_r != RUN_MAX) begin
      run_nxt = run_r + 1'b1;
    end else begin
      run_nxt = run_r;
    end
    out_data_nxt.smoothed_probability = mean;
    out_data_nxt.frame_passes         = passes;
    out_data_nxt.run_length           = run_nxt;
    out_data_nxt.endpoint_flag        = (run_nxt >= persist_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      prob_r <= (in_data.raw_probability > PROB_ONE) ? PROB_ONE : in_data.raw_probability;
      conf_r <= in_data.confidence;
    end
    if (out_load) begin
      out_data_r <= out_data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.clear) begin
        run_r <= '0;
      end else if (out_load) begin
        run_r <= run_nxt;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r     <= THRESHOLD_RESET;
      persist_r <= PERSIST_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_THRESHOLD:   thr_r     <= cfg_wdata;
        CFG_PERSISTENCE: persist_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

FILE: rtl/epq_checker.sv
// Port-level checker for the qualifier top level, bound to it.
module epq_checker import epq_pkg::*; (
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_valid,
  input logic                  in_stall,
  input in_item_t              in_data,
  input logic                  out_valid,
  input logic                  out_stall,
  input out_item_t             out_data,
  input logic                  cfg_wr_en,
  input logic [CFG_IDX_W-1:0]  cfg_index,
  input logic [CFG_DATA_W-1:0] cfg_wdata
);

  a_sample_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && in_data.kind == KIND_SAMPLE |=> in_stall)
    else $error("sample transaction did not occupy the block");

  a_fail_clears_run: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.frame_passes |-> out_data.run_length == 8'd0)
    else $error("failing frame with nonzero run");

  a_pass_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.frame_passes |-> out_data.run_length != 8'd0)
    else $error("passing frame with zero run");

  a_mean_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.smoothed_probability <= PROB_ONE)
    else $error("mean above one");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind endpoint_probability_qualifier_top epq_checker u_epq_checker (.*);

FILE: tb/endpoint_probability_qualifier_top_tb.sv
// Self-checking testbench for the endpoint probability qualifier top level.
`timescale 1ns / 1ps

module endpoint_probability_qualifier_top_tb;
  import epq_pkg::*;

  localparam int WINDOW      = WINDOW_DEFAULT;
  localparam int DRAIN_WAIT  = 30;
  localparam int EXP_DEPTH   = 16;

  class endpoint_scoreboard;
    logic [15:0] prob_hist [WINDOW];
    int unsigned fill;
    int unsigned slot;
    logic [17:0] prob_sum;
    logic [7:0]  run;
    logic [15:0] threshold;
    logic [7:0]  persistence;
    out_item_t   expected_verdicts [EXP_DEPTH];
    int unsigned exp_head;
    int unsigned exp_count;
    int          errors;

    function new();
      fill        = 0;
      slot        = 0;
      prob_sum    = '0;
      run         = '0;
      threshold   = THRESHOLD_RESET;
      persistence = PERSIST_RESET;
      exp_head    = 0;
      exp_count   = 0;
      errors      = 0;
    endfunction

    function void set_reg(cfg_idx_t idx, logic [15:0] val);
      if (idx == CFG_THRESHOLD) begin
        threshold = val;
      end else begin
        persistence = val[7:0];
      end
    endfunction

    function int pending();
      return int'(exp_count);
    endfunction

    function void note_frame(in_item_t it);
      logic [15:0] p;
      logic [17:0] mean;
      logic        pass;
      out_item_t   v;
      if (it.kind == KIND_RESTART) begin
        fill     = 0;
        slot     = 0;
        prob_sum = '0;
        run      = '0;
        return;
      end
      p = (it.raw_probability > PROB_ONE) ? PROB_ONE : it.raw_probability;
      if (fill >= WINDOW) begin
        prob_sum = prob_sum - 18'(prob_hist[slot]);
      end else begin
        fill++;
      end
      prob_hist[slot] = p;
      prob_sum = prob_sum + 18'(p);
      slot = (slot + 1) % WINDOW;
      mean = prob_sum / 18'(fill);
      pass = (mean[15:0] >= threshold) && (it.confidence > CONF_HALF);
      if (!pass) begin
        run = '0;
      end else if (run != RUN_MAX) begin
        run++;
      end
      v.smoothed_probability = mean[15:0];
      v.frame_passes         = pass;
      v.run_length           = run;
      v.endpoint_flag        = (run >= persistence);
      expected_verdicts[(exp_head + exp_count) % EXP_DEPTH] = v;
      exp_count++;
    endfunction

    function void report(string field, int exp_val, int act_val);
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d",
               $time, field, exp_val, act_val);
    endfunction

    function void check_verdict(out_item_t got);
      out_item_t exp_v;
      if (exp_count == 0) begin
        report("unexpected transaction, smoothed_probability", -1,
               int'(got.smoothed_probability));
        return;
      end
      exp_v = expected_verdicts[exp_head];
      exp_head = (exp_head + 1) % EXP_DEPTH;
      exp_count--;
      if (got.smoothed_probability !== exp_v.smoothed_probability)
        report("smoothed_probability", int'(exp_v.smoothed_probability),
               int'(got.smoothed_probability));
      if (got.frame_passes !== exp_v.frame_passes)
        report("frame_passes", int'(exp_v.frame_passes), int'(got.frame_passes));
      if (got.run_length !== exp_v.run_length)
        report("run_length", int'(exp_v.run_length), int'(got.run_length));
      if (got.endpoint_flag !== exp_v.endpoint_flag)
        report("endpoint_flag", int'(exp_v.endpoint_flag), int'(got.endpoint_flag));
    endfunction
  endclass

  logic                  clk;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_THRESHOLD;
  logic [CFG_DATA_W-1:0] cfg_wdata = '0;

  bit calm = 1'b0;
  endpoint_scoreboard sb = new();

  endpoint_probability_qualifier_top #(.WINDOW(WINDOW)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= !calm && ($urandom_range(99, 0) < 9);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      sb.check_verdict(out_data);
    end
  end

  task automatic send_frame(input in_item_t it);
    while (!calm && $urandom_range(99, 0) < 9) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    sb.note_frame(it);
  endtask

  // Hold off until every expected transaction is out and the block is idle.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  task automatic configure(input logic [15:0] thr, input logic [15:0] pers_word);
    cfg_wr_en <= 1'b1;
    cfg_index <= CFG_THRESHOLD;
    cfg_wdata <= thr;
    @(posedge clk);
    sb.set_reg(CFG_THRESHOLD, thr);
    cfg_index <= CFG_PERSISTENCE;
    cfg_wdata <= pers_word;
    @(posedge clk);
    sb.set_reg(CFG_PERSISTENCE, pers_word);
    cfg_wr_en <= 1'b0;
  endtask

  function automatic in_item_t frame(kind_t k, logic [15:0] p, logic [15:0] c);
    in_item_t it;
    it.kind            = k;
    it.raw_probability = p;
    it.confidence      = c;
    return it;
  endfunction

  function automatic in_item_t random_frame(logic [15:0] thr, bit long_runs);
    in_item_t    it;
    int unsigned r;
    int unsigned lo;
    it.kind = (!long_runs && $urandom_range(99, 0) < 3) ? KIND_RESTART : KIND_SAMPLE;
    r  = $urandom_range(99, 0);
    lo = (thr > 3000) ? thr - 3000 : 0;
    if (lo > 32768) lo = 30000;
    if (r < 50) begin
      it.raw_probability = 16'($urandom_range(32768, lo));
    end else if (r < 70) begin
      it.raw_probability = 16'($urandom);
    end else if (r < 85) begin
      case ($urandom_range(3, 0))
        0:       it.raw_probability = 16'd0;
        1:       it.raw_probability = PROB_ONE - 16'd1;
        2:       it.raw_probability = PROB_ONE;
        default: it.raw_probability = 16'hFFFF;
      endcase
    end else begin
      it.raw_probability = 16'($urandom_range(32768, 0));
    end
    r = $urandom_range(99, 0);
    if (long_runs || r < 75) begin
      it.confidence = 16'($urandom_range(65535, 16385));
    end else if (r < 85) begin
      it.confidence = CONF_HALF + 16'($urandom_range(1, 0));
    end else begin
      it.confidence = 16'($urandom);
    end
    return it;
  endfunction

  task automatic random_phase(input logic [15:0] thr, input logic [15:0] pers_word,
                              input int count, input bit long_runs);
    configure(thr, pers_word);
    for (int i = 0; i < count; i++) begin
      send_frame(random_frame(thr, long_runs));
      if ($urandom_range(99, 0) == 0) drain();
    end
    drain();
  endtask

  initial begin
    #5_000_000;
    $display("Test completed with failures");
    $finish;
  end

  initial begin
    logic [15:0] thr;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: register reset values
    send_frame(frame(KIND_SAMPLE, PROB_ONE, 16'd32768));
    send_frame(frame(KIND_SAMPLE, 16'hFFFF, 16'hFFFF));
    send_frame(frame(KIND_SAMPLE, PROB_ONE, CONF_HALF + 16'd1));
    send_frame(frame(KIND_SAMPLE, 16'd30000, CONF_HALF));
    send_frame(frame(KIND_SAMPLE, 16'd0, 16'd0));
    send_frame(frame(KIND_RESTART, 16'd0, 16'd0));
    send_frame(frame(KIND_SAMPLE, THRESHOLD_RESET, CONF_HALF + 16'd1));
    send_frame(frame(KIND_SAMPLE, THRESHOLD_RESET - 16'd1, 16'd20000));
    for (int i = 0; i < WINDOW + 1; i++) begin
      send_frame(frame(KIND_SAMPLE, PROB_ONE, 16'd32768));
    end
    send_frame(frame(KIND_SAMPLE, 16'd0, 16'hFFFF));
    send_frame(frame(KIND_RESTART, 16'hFFFF, 16'hFFFF));
    send_frame(frame(KIND_SAMPLE, 16'd1, 16'h7FFF));
    drain();

    // directed: register extremes
    configure(16'd0, 16'd0);
    send_frame(frame(KIND_SAMPLE, 16'd0, CONF_HALF));
    send_frame(frame(KIND_SAMPLE, 16'd0, 16'hFFFF));
    drain();
    configure(16'hFFFF, 16'hFF);
    send_frame(frame(KIND_SAMPLE, PROB_ONE, 16'hFFFF));
    send_frame(frame(KIND_SAMPLE, 16'hFFFF, 16'hFFFF));
    drain();
    configure(PROB_ONE, 16'd1);
    send_frame(frame(KIND_SAMPLE, PROB_ONE, 16'hFFFF));
    send_frame(frame(KIND_SAMPLE, PROB_ONE, 16'hFFFF));
    drain();

    calm = 1'b1;
    random_phase(THRESHOLD_RESET, {8'($urandom), PERSIST_RESET}, 250, 1'b0);
    calm = 1'b0;
    random_phase(16'd0, 16'hFF, 320, 1'b1);
    random_phase(PROB_ONE, 16'd1, 150, 1'b0);
    random_phase(16'hFFFF, 16'hFF00, 100, 1'b0);
    for (int ph = 0; ph < 4; ph++) begin
      thr = 16'($urandom_range(32768, 0));
      random_phase(thr, {8'($urandom), 8'($urandom_range(8, 1))}, 150, 1'b0);
    end

    drain();
    if (sb.errors == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
